/* rtl/sjc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjc_pkg
// Shared types, codes and constants of the stepper jog controller.
// ----------------------------------------------------------------------------
package sjc_pkg;

    // Configuration register file geometry.
    localparam int NUM_REGS   = 6;
    localparam int CFG_INDEX_W = 3;
    localparam int PERIOD_W   = 16;

    typedef logic [2:0]          mode_t;
    typedef logic [1:0]          cmd_t;
    typedef logic [1:0]          speed_t;
    typedef logic [CFG_INDEX_W-1:0] reg_index_t;
    typedef logic [PERIOD_W-1:0] period_t;
    typedef period_t [NUM_REGS-1:0] period_bank_t;

    // Run modes.
    localparam mode_t MODE_STOP      = 3'd0;
    localparam mode_t MODE_SLOW_FWD  = 3'd1;
    localparam mode_t MODE_FAST_FWD  = 3'd2;
    localparam mode_t MODE_SLOW_BACK = 3'd3;
    localparam mode_t MODE_FAST_BACK = 3'd4;

    // Item kinds.
    localparam cmd_t CMD_BYTE = 2'd0;
    localparam cmd_t CMD_POLL = 2'd1;
    localparam cmd_t CMD_TICK = 2'd2;

    // Command byte decoding.
    localparam logic [7:0] BYTE_STOP     = 8'hFF;
    localparam logic [3:0] HI_NIBBLE_MAX = 4'h3;
    localparam logic [3:0] LO_NIBBLE_MIN = 4'h1;
    localparam logic [3:0] LO_NIBBLE_MAX = 4'h3;

    // Speeds.
    localparam speed_t SPEED_LOW  = 2'd0;
    localparam speed_t SPEED_MID  = 2'd1;
    localparam speed_t SPEED_HIGH = 2'd2;

    // Register indexes.
    localparam reg_index_t REG_SLOW_LOW  = 3'd0;
    localparam reg_index_t REG_SLOW_MID  = 3'd1;
    localparam reg_index_t REG_SLOW_HIGH = 3'd2;
    localparam reg_index_t REG_FAST_LOW  = 3'd3;
    localparam reg_index_t REG_FAST_MID  = 3'd4;
    localparam reg_index_t REG_FAST_HIGH = 3'd5;

    // One input word.
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] rx_byte;
        logic       right_limit_hit;
        logic       left_limit_hit;
    } item_t;

    // One result word.
    typedef struct packed {
        mode_t       run_mode;
        logic        drive_enable;
        logic        direction_pin;
        logic        pulses_on;
        period_t     pulse_period;
        logic [14:0] pulse_compare;
        logic [31:0] step_count;
        logic        sample_request;
    } result_t;

    // Reset value of each period register.
    function automatic period_t period_reset(input reg_index_t idx);
        period_t val;
        case (idx)
            REG_SLOW_LOW:  val = 16'd37500;
            REG_SLOW_MID:  val = 16'd18750;
            REG_SLOW_HIGH: val = 16'd9375;
            REG_FAST_LOW:  val = 16'd1000;
            REG_FAST_MID:  val = 16'd500;
            REG_FAST_HIGH: val = 16'd200;
            default:       val = '0;
        endcase
        return val;
    endfunction

    // High nibble of a command byte to its run mode.
    function automatic mode_t nibble_to_mode(input logic [1:0] hi);
        mode_t m;
        case (hi)
            2'd0:    m = MODE_SLOW_FWD;
            2'd1:    m = MODE_SLOW_BACK;
            2'd2:    m = MODE_FAST_FWD;
            default: m = MODE_FAST_BACK;
        endcase
        return m;
    endfunction

    function automatic logic mode_is_slow(input mode_t m);
        return (m == MODE_SLOW_FWD) || (m == MODE_SLOW_BACK);
    endfunction

    function automatic logic mode_is_back(input mode_t m);
        return (m == MODE_SLOW_BACK) || (m == MODE_FAST_BACK);
    endfunction

endpackage

/* rtl/sjc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjc_if
// Valid/ready channels of the stepper jog controller: input and result words.
// ----------------------------------------------------------------------------
interface sjc_in_if;
    logic                valid;
    logic                ready;
    sjc_pkg::cmd_t       cmd;
    logic [7:0]          rx_byte;
    logic                right_limit_hit;
    logic                left_limit_hit;

    modport source (output valid, cmd, rx_byte, right_limit_hit, left_limit_hit,
                    input ready);
    modport sink   (input valid, cmd, rx_byte, right_limit_hit, left_limit_hit,
                    output ready);
endinterface

interface sjc_out_if;
    logic                valid;
    logic                ready;
    sjc_pkg::mode_t      run_mode;
    logic                drive_enable;
    logic                direction_pin;
    logic                pulses_on;
    sjc_pkg::period_t    pulse_period;
    logic [14:0]         pulse_compare;
    logic [31:0]         step_count;
    logic                sample_request;

    modport source (output valid, run_mode, drive_enable, direction_pin, pulses_on,
                    pulse_period, pulse_compare, step_count, sample_request,
                    input ready);
    modport sink   (input valid, run_mode, drive_enable, direction_pin, pulses_on,
                    pulse_period, pulse_compare, step_count, sample_request,
                    output ready);
endinterface

/* rtl/sjc_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjc_cfg_regs
// Period register file, written through the plain configuration port.
// ----------------------------------------------------------------------------
module sjc_cfg_regs (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  sjc_pkg::reg_index_t   cfg_index,
    input  sjc_pkg::period_t      cfg_data,
    output sjc_pkg::period_bank_t periods
);

    sjc_pkg::period_bank_t periods_reg;
    sjc_pkg::period_bank_t periods_next;

    // Writes beyond the last register are dropped.
    always_comb
    begin
        periods_next = periods_reg;
        if (cfg_we && (cfg_index < sjc_pkg::CFG_INDEX_W'(sjc_pkg::NUM_REGS)))
        begin
            periods_next[cfg_index] = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sjc_pkg::NUM_REGS; i++)
            begin
                periods_reg[i] <= sjc_pkg::period_reset(sjc_pkg::CFG_INDEX_W'(i));
            end
        end
        else
        begin
            periods_reg <= periods_next;
        end
    end

    assign periods = periods_reg;

endmodule

/* rtl/sjc_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjc_core
// Jog state machine: applies one word per cycle while fire is high to the
// controller state and forms the result word from the updated state.
// ----------------------------------------------------------------------------
module sjc_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  sjc_pkg::item_t        item,
    input  sjc_pkg::period_bank_t periods,
    output sjc_pkg::result_t      result
);

    sjc_pkg::mode_t   cur_mode_reg,  cur_mode_next;
    sjc_pkg::mode_t   req_mode_reg,  req_mode_next;
    sjc_pkg::speed_t  req_speed_reg, req_speed_next;
    logic             start_pend_reg, start_pend_next;
    logic [31:0]      tick_count_reg, tick_count_next;
    sjc_pkg::period_t period_reg,    period_next;
    logic             dir_reg,       dir_next;
    logic             enable_reg,    enable_next;
    logic             pulse_run_reg, pulse_run_next;
    logic             sample;

    logic [3:0]           hi_nib;
    logic [3:0]           lo_nib;
    logic                 byte_valid;
    logic                 limit;
    sjc_pkg::speed_t      speed_sel;
    sjc_pkg::reg_index_t  period_idx;

    // Command byte fields and the period register picked for the current run.
    always_comb
    begin
        hi_nib     = item.rx_byte[7:4];
        lo_nib     = item.rx_byte[3:0];
        byte_valid = (hi_nib <= sjc_pkg::HI_NIBBLE_MAX) &&
                     (lo_nib >= sjc_pkg::LO_NIBBLE_MIN) &&
                     (lo_nib <= sjc_pkg::LO_NIBBLE_MAX);
        limit      = sjc_pkg::mode_is_back(cur_mode_reg) ? item.left_limit_hit
                                                         : item.right_limit_hit;
        speed_sel  = (req_speed_reg > sjc_pkg::SPEED_HIGH) ? sjc_pkg::SPEED_HIGH
                                                           : req_speed_reg;
        period_idx = (sjc_pkg::mode_is_slow(cur_mode_reg) ? sjc_pkg::REG_SLOW_LOW
                                                          : sjc_pkg::REG_FAST_LOW)
                     + sjc_pkg::CFG_INDEX_W'(speed_sel);
    end

    // Next state for the word in hand.
    always_comb
    begin
        cur_mode_next   = cur_mode_reg;
        req_mode_next   = req_mode_reg;
        req_speed_next  = req_speed_reg;
        start_pend_next = start_pend_reg;
        tick_count_next = tick_count_reg;
        period_next     = period_reg;
        dir_next        = dir_reg;
        enable_next     = enable_reg;
        pulse_run_next  = pulse_run_reg;
        sample          = 1'b0;

        case (item.cmd)
            sjc_pkg::CMD_BYTE:
            begin
                if (item.rx_byte == sjc_pkg::BYTE_STOP)
                begin
                    req_mode_next = sjc_pkg::MODE_STOP;
                end
                else if (byte_valid)
                begin
                    req_mode_next  = sjc_pkg::nibble_to_mode(hi_nib[1:0]);
                    req_speed_next = lo_nib[1:0] - 2'd1;
                end
            end

            sjc_pkg::CMD_POLL:
            begin
                if (cur_mode_reg == sjc_pkg::MODE_STOP)
                begin
                    // In Stop: adopt a pending mode, or park the drive.
                    if (req_mode_reg != sjc_pkg::MODE_STOP)
                    begin
                        cur_mode_next = req_mode_reg;
                    end
                    else
                    begin
                        enable_next     = 1'b0;
                        pulse_run_next  = 1'b0;
                        start_pend_next = 1'b1;
                        tick_count_next = '0;
                    end
                end
                else if ((req_mode_reg == sjc_pkg::MODE_STOP) || limit)
                begin
                    cur_mode_next = sjc_pkg::MODE_STOP;
                    req_mode_next = sjc_pkg::MODE_STOP;
                end
                else
                begin
                    // Running: start once per run, then keep sampling in slow modes.
                    if (start_pend_reg)
                    begin
                        period_next     = periods[period_idx];
                        dir_next        = sjc_pkg::mode_is_back(cur_mode_reg);
                        pulse_run_next  = 1'b1;
                        enable_next     = 1'b1;
                        start_pend_next = 1'b0;
                    end
                    sample = sjc_pkg::mode_is_slow(cur_mode_reg);
                end
            end

            sjc_pkg::CMD_TICK:
            begin
                if (pulse_run_reg)
                begin
                    tick_count_next = tick_count_reg + 32'd1;
                end
            end

            default:
            begin
                // Unused item kind leaves the state alone.
            end
        endcase
    end

    // State registers advance only when a word is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_mode_reg   <= sjc_pkg::MODE_STOP;
            req_mode_reg   <= sjc_pkg::MODE_STOP;
            req_speed_reg  <= sjc_pkg::SPEED_LOW;
            start_pend_reg <= 1'b1;
            tick_count_reg <= '0;
            period_reg     <= '0;
            dir_reg        <= 1'b0;
            enable_reg     <= 1'b0;
            pulse_run_reg  <= 1'b0;
        end
        else if (fire)
        begin
            cur_mode_reg   <= cur_mode_next;
            req_mode_reg   <= req_mode_next;
            req_speed_reg  <= req_speed_next;
            start_pend_reg <= start_pend_next;
            tick_count_reg <= tick_count_next;
            period_reg     <= period_next;
            dir_reg        <= dir_next;
            enable_reg     <= enable_next;
            pulse_run_reg  <= pulse_run_next;
        end
    end

    // Result word reflects the state after the word.
    always_comb
    begin
        result.run_mode       = cur_mode_next;
        result.drive_enable   = enable_next;
        result.direction_pin  = dir_next;
        result.pulses_on      = pulse_run_next;
        result.pulse_period   = period_next;
        result.pulse_compare  = period_next[15:1];
        result.step_count     = tick_count_next;
        result.sample_request = sample;
    end

endmodule

/* rtl/stepper_jog_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_jog_controller
// Stepper jog controller: command bytes, polls and timer ticks in, one
// status word out for every word in.
//
//   Channel   Direction  Handshake     Payload
//   in_ch     sink       valid/ready   cmd, rx_byte, right/left_limit_hit
//   out_ch    source     valid/ready   run_mode .. sample_request
//   cfg       write      cfg_we        cfg_index (3 bits), cfg_data (16 bits)
//
// One word per cycle sustained while out_ch.ready stays high. A word taken
// sits in the input register, passes through the state update into the
// result register, and can then leave on out_ch. Reset clears the jog state
// and loads the default periods. A stalled result holds in the result
// register; one more word waits in the input register, after which
// in_ch.ready drops until out_ch drains.
// ----------------------------------------------------------------------------
module stepper_jog_controller (
    input  logic                clk,
    input  logic                rst_n,
    sjc_in_if.sink              in_ch,
    sjc_out_if.source           out_ch,
    input  logic                cfg_we,
    input  sjc_pkg::reg_index_t cfg_index,
    input  sjc_pkg::period_t    cfg_data
);

    sjc_pkg::period_bank_t periods;
    sjc_pkg::item_t        item_reg;
    sjc_pkg::item_t        item_in;
    logic                  item_valid_reg, item_valid_next;
    sjc_pkg::result_t      result_next;
    sjc_pkg::result_t      out_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  advance;
    logic                  in_take;

    sjc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .periods   (periods)
    );

    sjc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (advance),
        .item    (item_reg),
        .periods (periods),
        .result  (result_next)
    );

    // Handshake: the held word moves on whenever the result register is free.
    assign advance     = item_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !item_valid_reg || advance;
    assign in_take     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        item_in.cmd             = in_ch.cmd;
        item_in.rx_byte         = in_ch.rx_byte;
        item_in.right_limit_hit = in_ch.right_limit_hit;
        item_in.left_limit_hit  = in_ch.left_limit_hit;

        item_valid_next = in_take ? 1'b1 : (advance ? 1'b0 : item_valid_reg);
        out_valid_next  = advance ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);
    end

    // Control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= item_in;
        end
        if (advance)
        begin
            out_reg <= result_next;
        end
    end

    // Result channel.
    assign out_ch.valid          = out_valid_reg;
    assign out_ch.run_mode       = out_reg.run_mode;
    assign out_ch.drive_enable   = out_reg.drive_enable;
    assign out_ch.direction_pin  = out_reg.direction_pin;
    assign out_ch.pulses_on      = out_reg.pulses_on;
    assign out_ch.pulse_period   = out_reg.pulse_period;
    assign out_ch.pulse_compare  = out_reg.pulse_compare;
    assign out_ch.step_count     = out_reg.step_count;
    assign out_ch.sample_request = out_reg.sample_request;

    // The driver enable and the pulse generator are always switched together.
    a_enable_with_pulses : assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.drive_enable == out_ch.pulses_on))
        else $error("drive enable and pulse run disagree");

    // The compare value is always half the latched period.
    a_compare_half : assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.pulse_compare == out_ch.pulse_period[15:1]))
        else $error("pulse compare is not half the period");

    // A sample request only comes from a slow mode with pulses running.
    a_sample_slow : assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.sample_request) |->
        (((out_ch.run_mode == sjc_pkg::MODE_SLOW_FWD) ||
          (out_ch.run_mode == sjc_pkg::MODE_SLOW_BACK)) && out_ch.pulses_on))
        else $error("sample request outside a running slow mode");

    // Input back-pressure only when both stages are full and the output stalls.
    a_ready_drop : assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (item_valid_reg && out_valid_reg && !out_ch.ready))
        else $error("input stalled without a full pipeline");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stepper jog controller. Command bytes, polls and
// timer ticks go in on the input channel, and both channels idle at random.
// A behavioral copy of the jog logic predicts the status word for every
// accepted input word. Each status word that comes out is checked field by
// field against the oldest prediction. The period registers are rewritten
// between phases, the extreme values among them.
// ----------------------------------------------------------------------------
module tb;

    import sjc_pkg::*;

    // The one item kind that the package leaves unnamed; the block ignores it.
    localparam cmd_t CMD_UNUSED = 2'd3;
    localparam int   IDLE_PCT    = 26;
    localparam int   CYCLE_LIMIT = 200000;
    localparam int   PHASE_WORDS = 250;

    // High nibble of a mode byte to the run mode that it selects.
    localparam mode_t MODE_OF_NIBBLE [4] = '{MODE_SLOW_FWD, MODE_SLOW_BACK,
                                             MODE_FAST_FWD, MODE_FAST_BACK};

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    reg_index_t cfg_index;
    period_t    cfg_data;

    sjc_in_if  in_ch ();
    sjc_out_if out_ch ();

    stepper_jog_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Jog state as predicted from the accepted input words.
    period_bank_t period_cfg;
    mode_t        cur_mode;
    mode_t        req_mode;
    speed_t       req_speed;
    logic         start_armed;
    logic [31:0]  steps;
    period_t      period_now;
    logic         dir_now;
    logic         drive_on;
    logic         pulsing;

    result_t status_q [$];
    int      err_count = 0;
    int      cycle_count = 0;
    bit      steady = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Give up on a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side backpressure: random stalls unless a steady stretch runs.
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready = steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic reset_model();
        for (int i = 0; i < NUM_REGS; i++)
        begin
            period_cfg[i] = period_reset(reg_index_t'(i));
        end
        cur_mode    = MODE_STOP;
        req_mode    = MODE_STOP;
        req_speed   = SPEED_LOW;
        start_armed = 1'b1;
        steps       = '0;
        period_now  = '0;
        dir_now     = 1'b0;
        drive_on    = 1'b0;
        pulsing     = 1'b0;
    endtask

    // Apply one input word to the predicted state and return the status word.
    function automatic result_t next_status(input item_t w);
        result_t    r;
        logic       sample;
        logic       slow;
        logic       back;
        logic       limit;
        reg_index_t sel;
        sample = 1'b0;
        slow   = (cur_mode == MODE_SLOW_FWD) || (cur_mode == MODE_SLOW_BACK);
        back   = (cur_mode == MODE_SLOW_BACK) || (cur_mode == MODE_FAST_BACK);
        case (w.cmd)
            CMD_BYTE:
            begin
                if (w.rx_byte == BYTE_STOP)
                begin
                    req_mode = MODE_STOP;
                end
                else if (w.rx_byte[7:4] <= HI_NIBBLE_MAX &&
                         w.rx_byte[3:0] >= LO_NIBBLE_MIN &&
                         w.rx_byte[3:0] <= LO_NIBBLE_MAX)
                begin
                    req_mode  = MODE_OF_NIBBLE[w.rx_byte[5:4]];
                    req_speed = speed_t'(w.rx_byte[3:0] - LO_NIBBLE_MIN);
                end
            end
            CMD_POLL:
            begin
                if (cur_mode == MODE_STOP)
                begin
                    // Adopt a pending mode, or settle the drive fully at rest.
                    if (req_mode != MODE_STOP)
                    begin
                        cur_mode = req_mode;
                    end
                    else
                    begin
                        drive_on    = 1'b0;
                        pulsing     = 1'b0;
                        start_armed = 1'b1;
                        steps       = '0;
                    end
                end
                else
                begin
                    limit = back ? w.left_limit_hit : w.right_limit_hit;
                    if (req_mode == MODE_STOP || limit)
                    begin
                        cur_mode = MODE_STOP;
                        req_mode = MODE_STOP;
                    end
                    else
                    begin
                        // The period is latched only on the first poll of a run.
                        if (start_armed)
                        begin
                            sel = slow ? REG_SLOW_LOW : REG_FAST_LOW;
                            sel = reg_index_t'(sel + ((req_speed > SPEED_HIGH) ?
                                                      SPEED_HIGH : req_speed));
                            period_now  = period_cfg[sel];
                            dir_now     = back;
                            pulsing     = 1'b1;
                            drive_on    = 1'b1;
                            start_armed = 1'b0;
                        end
                        sample = slow;
                    end
                end
            end
            CMD_TICK:
            begin
                if (pulsing)
                begin
                    steps = steps + 32'd1;
                end
            end
            default:
            begin
            end
        endcase
        r.run_mode       = cur_mode;
        r.drive_enable   = drive_on;
        r.direction_pin  = dir_now;
        r.pulses_on      = pulsing;
        r.pulse_period   = period_now;
        r.pulse_compare  = period_now[15:1];
        r.step_count     = steps;
        r.sample_request = sample;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    // Every accepted status word is matched against the oldest prediction.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (status_q.size() == 0)
            begin
                $error("status word with no prediction waiting");
                err_count++;
            end
            else
            begin
                want = status_q.pop_front();
                check_field("run_mode", 32'(want.run_mode), 32'(out_ch.run_mode));
                check_field("drive_enable", 32'(want.drive_enable),
                            32'(out_ch.drive_enable));
                check_field("direction_pin", 32'(want.direction_pin),
                            32'(out_ch.direction_pin));
                check_field("pulses_on", 32'(want.pulses_on), 32'(out_ch.pulses_on));
                check_field("pulse_period", 32'(want.pulse_period),
                            32'(out_ch.pulse_period));
                check_field("pulse_compare", 32'(want.pulse_compare),
                            32'(out_ch.pulse_compare));
                check_field("step_count", want.step_count, out_ch.step_count);
                check_field("sample_request", 32'(want.sample_request),
                            32'(out_ch.sample_request));
            end
        end
    end

    // Send one input word. Called at a falling edge and returns at one; valid
    // stays high so that back-to-back words need no gap.
    task automatic send_word(input cmd_t cmd, input logic [7:0] rx_byte,
                             input logic right_hit, input logic left_hit);
        item_t w;
        w.cmd             = cmd;
        w.rx_byte         = rx_byte;
        w.right_limit_hit = right_hit;
        w.left_limit_hit  = left_hit;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.cmd             = w.cmd;
        in_ch.rx_byte         = w.rx_byte;
        in_ch.right_limit_hit = w.right_limit_hit;
        in_ch.left_limit_hit  = w.left_limit_hit;
        in_ch.valid           = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        status_q.push_back(next_status(w));
        @(negedge clk);
    endtask

    // Stop sending and let every predicted word come out before a register write.
    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (status_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_period(input reg_index_t idx, input period_t val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        period_cfg[idx] = val;
    endtask

    // Polls and ticks at rest, the unused item kind, and bytes that select nothing.
    task automatic test_idle_behavior();
        send_word(CMD_POLL, 8'h00, 1'b0, 1'b0);
        send_word(CMD_TICK, 8'hFF, 1'b1, 1'b1);
        send_word(CMD_UNUSED, 8'h21, 1'b1, 1'b1);
        send_word(CMD_BYTE, 8'h00, 1'b0, 1'b0);
        send_word(CMD_BYTE, 8'h34, 1'b0, 1'b0);
        send_word(CMD_BYTE, 8'h14, 1'b0, 1'b0);
        send_word(CMD_BYTE, 8'hFE, 1'b0, 1'b0);
    endtask

    // Runs at the reset periods: start, ignored speed change, limit switches,
    // stop request, and the clearing poll once back at rest.
    task automatic test_jog_runs();
        send_word(CMD_BYTE, 8'h01, 1'b0, 1'b0);
        send_word(CMD_POLL, 8'h00, 1'b0, 1'b0);
        send_word(CMD_POLL, 8'h00, 1'b0, 1'b0);
        send_word(CMD_BYTE, 8'h33, 1'b0, 1'b0);
        send_word(CMD_TICK, 8'h00, 1'b0, 1'b0);
        send_word(CMD_POLL, 8'h00, 1'b0, 1'b1);
        send_word(CMD_POLL, 8'h00, 1'b1, 1'b0);
        send_word(CMD_POLL, 8'h00, 1'b0, 1'b0);
        send_word(CMD_BYTE, 8'h23, 1'b0, 1'b0);
        send_word(CMD_POLL, 8'h00, 1'b0, 1'b0);
        send_word(CMD_POLL, 8'h00, 1'b0, 1'b0);
        send_word(CMD_TICK, 8'h00, 1'b0, 1'b0);
        send_word(CMD_BYTE, BYTE_STOP, 1'b0, 1'b0);
        send_word(CMD_POLL, 8'h00, 1'b0, 1'b0);
        send_word(CMD_POLL, 8'h00, 1'b0, 1'b0);
        send_word(CMD_BYTE, 8'h12, 1'b0, 1'b0);
        send_word(CMD_POLL, 8'h00, 1'b0, 1'b0);
        send_word(CMD_POLL, 8'h00, 1'b1, 1'b0);
        send_word(CMD_POLL, 8'h00, 1'b0, 1'b1);
        send_word(CMD_POLL, 8'h00, 1'b0, 1'b0);
    endtask

    // Every mode and speed with all periods at the smallest, largest and zero.
    task automatic test_period_extremes();
        period_t sweep [3];
        sweep = '{16'd1, 16'hFFFF, 16'd0};
        foreach (sweep[s])
        begin
            wait_drained();
            for (int i = 0; i < NUM_REGS; i++)
            begin
                write_period(reg_index_t'(i), sweep[s]);
            end
            for (int hi = 0; hi <= int'(HI_NIBBLE_MAX); hi++)
            begin
                for (int lo = int'(LO_NIBBLE_MIN); lo <= int'(LO_NIBBLE_MAX); lo++)
                begin
                    send_word(CMD_BYTE, {4'(hi), 4'(lo)}, 1'b0, 1'b0);
                    send_word(CMD_POLL, 8'h00, 1'b0, 1'b0);
                    send_word(CMD_POLL, 8'h00, 1'b0, 1'b0);
                    send_word(CMD_BYTE, BYTE_STOP, 1'b0, 1'b0);
                    send_word(CMD_POLL, 8'h00, 1'b0, 1'b0);
                    send_word(CMD_POLL, 8'h00, 1'b0, 1'b0);
                end
            end
        end
    endtask

    // Random traffic in phases, with fresh periods before each phase. Most
    // bytes select a mode so that runs start, tick and stop often.
    task automatic test_random_traffic();
        int         pick;
        cmd_t       cmd;
        logic [7:0] rx_byte;
        period_t    val;
        for (int phase = 0; phase < 7; phase++)
        begin
            wait_drained();
            for (int i = 0; i < NUM_REGS; i++)
            begin
                pick = $urandom_range(0, 9);
                val  = (pick == 0) ? 16'd1 :
                       (pick == 1) ? 16'hFFFF : period_t'($urandom_range(1, 65535));
                write_period(reg_index_t'(i), val);
            end
            steady = (phase == 3);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                pick    = $urandom_range(0, 99);
                rx_byte = 8'($urandom_range(0, 255));
                if (pick < 30)
                begin
                    cmd  = CMD_BYTE;
                    pick = $urandom_range(0, 9);
                    if (pick < 6)
                    begin
                        rx_byte = {4'($urandom_range(0, int'(HI_NIBBLE_MAX))),
                                   4'($urandom_range(int'(LO_NIBBLE_MIN),
                                                     int'(LO_NIBBLE_MAX)))};
                    end
                    else if (pick < 8)
                    begin
                        rx_byte = BYTE_STOP;
                    end
                end
                else if (pick < 62)
                begin
                    cmd = CMD_POLL;
                end
                else if (pick < 95)
                begin
                    cmd = CMD_TICK;
                end
                else
                begin
                    cmd = CMD_UNUSED;
                end
                send_word(cmd, rx_byte, $urandom_range(0, 99) < 15,
                          $urandom_range(0, 99) < 15);
            end
            steady = 1'b0;
        end
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        in_ch.valid           = 1'b0;
        in_ch.cmd             = CMD_BYTE;
        in_ch.rx_byte         = '0;
        in_ch.right_limit_hit = 1'b0;
        in_ch.left_limit_hit  = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = REG_SLOW_LOW;
        cfg_data              = '0;
        reset_model();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_idle_behavior();
        test_jog_runs();
        test_period_extremes();
        test_random_traffic();

        // Drain, then give any stray word time to show up.
        in_ch.valid = 1'b0;
        while (status_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
        if (err_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/sjc_pkg.sv
rtl/sjc_if.sv
rtl/sjc_cfg_regs.sv
rtl/sjc_core.sv
rtl/stepper_jog_controller.sv
test/tb.sv
